/* hdl/sgs_pkg.sv */
// Shared types, widths, reset values and command codes for the scan gap steering selector.
// No dependencies.
`default_nettype none

package sgs_pkg;

   localparam int RANGE_W = 16;
   localparam int MINW_W  = 12;
   localparam int STEP_W  = 20;
   localparam int ROT_W   = 28;
   localparam int CMD_W   = 4;
   localparam int CSR_DW  = 20;
   localparam int CSR_AW  = 2;

   localparam int DEF_MAX_BEAMS = 4096;
   localparam int DEF_FRAC_BITS = 16;

   localparam logic [RANGE_W-1:0] RST_SAFE_RANGE = 16'd200;
   localparam logic [MINW_W-1:0]  RST_MIN_BEAMS  = 12'd2;
   localparam logic [STEP_W-1:0]  RST_ANGLE_STEP = 20'd23069;

   typedef enum logic [CSR_AW-1:0] {
      CSR_SAFE_RANGE = 2'd0,
      CSR_MIN_BEAMS  = 2'd1,
      CSR_ANGLE_STEP = 2'd2
   } csr_idx_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_BACK    = 4'd0,
      CMD_FWD     = 4'd1,
      CMD_LEFT60  = 4'd2,
      CMD_LEFT30  = 4'd3,
      CMD_LEFT10  = 4'd4,
      CMD_LEFT5   = 4'd5,
      CMD_LEFT2   = 4'd6,
      CMD_RIGHT60 = 4'd7,
      CMD_RIGHT30 = 4'd8,
      CMD_RIGHT10 = 4'd9,
      CMD_RIGHT5  = 4'd10,
      CMD_RIGHT2  = 4'd11
   } cmd_type;

   // turn band of a rotation, widest first
   typedef enum logic [2:0] {
      BAND_60  = 3'd0,
      BAND_30  = 3'd1,
      BAND_10  = 3'd2,
      BAND_5   = 3'd3,
      BAND_2   = 3'd4,
      BAND_FWD = 3'd5
   } band_type;

   typedef struct packed {
      logic vld;
      logic valley;
      logic last;
   } stage_ctl_type;

   function automatic cmd_type cmd_for(input logic left, input band_type band);
      cmd_type c;
      unique case (band)
         BAND_60: c = left ? CMD_LEFT60 : CMD_RIGHT60;
         BAND_30: c = left ? CMD_LEFT30 : CMD_RIGHT30;
         BAND_10: c = left ? CMD_LEFT10 : CMD_RIGHT10;
         BAND_5:  c = left ? CMD_LEFT5  : CMD_RIGHT5;
         BAND_2:  c = left ? CMD_LEFT2  : CMD_RIGHT2;
         default: c = CMD_FWD;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

/* hdl/scan_gap_steering_selector.sv */
// Top level of the scan gap steering selector: control registers and the three-part pipeline.
// Depends on sgs_pkg, sgs_front, sgs_heading, sgs_select.
//
//   port group  dir  width        contents
//   req_        in   16+1+1       beam range, invalid flag, last beam of scan
//   rsp_        out  32+1         steering command and rotation, valley flag
//   csr_        in   2+20         register index and write data
//
// One beam is accepted per cycle while the pipeline does not stall. A result leaves after the last beam
// of a scan has passed the input, front, multiply, distance and result registers.
// Reset is synchronous and needs no clearing pass.
// The pipeline stalls only while a finished result waits and a second one is due.
`default_nettype none

module scan_gap_steering_selector #(
   parameter int MAX_BEAMS       = sgs_pkg::DEF_MAX_BEAMS,
   parameter int ANGLE_FRAC_BITS = sgs_pkg::DEF_FRAC_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [15:0]                 req_tdata,  // range_mm
   input  logic                        req_tuser,  // range_invalid
   input  logic                        req_tlast,  // last_beam
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [31:0]                 rsp_tdata,  // command[3:0], rotation_q16[31:4]
   output logic                        rsp_tuser,  // valley_found
   input  logic                        csr_we,
   input  logic [sgs_pkg::CSR_AW-1:0]  csr_addr,
   input  logic [sgs_pkg::CSR_DW-1:0]  csr_wdata
);
   import sgs_pkg::*;

   localparam int IDX_W = $clog2(MAX_BEAMS);

   logic [RANGE_W-1:0] safe_range_ff;
   logic [MINW_W-1:0]  min_beams_ff;
   logic [STEP_W-1:0]  angle_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         safe_range_ff <= RST_SAFE_RANGE;
         min_beams_ff  <= RST_MIN_BEAMS;
         angle_step_ff <= RST_ANGLE_STEP;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_SAFE_RANGE: safe_range_ff <= csr_wdata[RANGE_W-1:0];
            CSR_MIN_BEAMS:  min_beams_ff  <= csr_wdata[MINW_W-1:0];
            CSR_ANGLE_STEP: angle_step_ff <= csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   logic             adv;
   stage_ctl_type    front_ctl, head_ctl;
   logic [IDX_W-1:0] front_pos;
   logic [ROT_W-1:0] head_delta;
   band_type         head_band;
   logic             head_left;
   cmd_type          out_cmd;
   logic [ROT_W-1:0] out_rot;
   logic             out_found;

   sgs_front #(
      .MAX_BEAMS(MAX_BEAMS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_vld     (req_tvalid),
      .in_range   (req_tdata),
      .in_invalid (req_tuser),
      .in_last    (req_tlast),
      .safe_range (safe_range_ff),
      .min_beams  (min_beams_ff),
      .ctl_o      (front_ctl),
      .pos_o      (front_pos)
   );

   sgs_heading #(
      .IDX_W    (IDX_W),
      .FRAC_BITS(ANGLE_FRAC_BITS)
   ) u_heading (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .ctl_i   (front_ctl),
      .pos_i   (front_pos),
      .step_i  (angle_step_ff),
      .ctl_o   (head_ctl),
      .delta_o (head_delta),
      .band_o  (head_band),
      .left_o  (head_left)
   );

   sgs_select u_select (
      .clock     (clock),
      .reset     (reset),
      .ctl_i     (head_ctl),
      .delta_i   (head_delta),
      .band_i    (head_band),
      .left_i    (head_left),
      .adv       (adv),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_cmd   (out_cmd),
      .rsp_rot   (out_rot),
      .rsp_found (out_found)
   );

   assign req_tready = adv;
   assign rsp_tdata  = {out_rot, out_cmd};
   assign rsp_tuser  = out_found;

endmodule

`default_nettype wire

/* hdl/sgs_front.sv */
// Beam input register, safe test and run/index tracking; emits one control word per beam.
// Depends on sgs_pkg.
`default_nettype none

module sgs_front #(
   parameter int MAX_BEAMS = sgs_pkg::DEF_MAX_BEAMS,
   localparam int IDX_W = $clog2(MAX_BEAMS)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_vld,
   input  logic [sgs_pkg::RANGE_W-1:0] in_range,
   input  logic                        in_invalid,
   input  logic                        in_last,
   input  logic [sgs_pkg::RANGE_W-1:0] safe_range,
   input  logic [sgs_pkg::MINW_W-1:0]  min_beams,
   output sgs_pkg::stage_ctl_type      ctl_o,
   output logic [IDX_W-1:0]            pos_o
);
   import sgs_pkg::*;

   localparam int CW = (IDX_W > MINW_W) ? IDX_W : MINW_W;
   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_BEAMS - 1);

   logic               in_vld_ff;
   logic [RANGE_W-1:0] in_range_ff;
   logic               in_invalid_ff;
   logic               in_last_ff;
   logic [IDX_W-1:0]   index_ff, index_in;
   logic [IDX_W-1:0]   run_ff, run_in;
   stage_ctl_type      ctl_ff, ctl_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;

   logic             safe, closing, valley;
   logic [IDX_W-1:0] run_inc, idx_inc, run_end;

   always_comb begin
      safe     = in_invalid_ff || (in_range_ff >= safe_range);
      run_inc  = (run_ff < IDX_MAX) ? run_ff + IDX_W'(1) : run_ff;
      idx_inc  = (index_ff < IDX_MAX) ? index_ff + IDX_W'(1) : index_ff;
      closing  = !safe || in_last_ff;
      run_end  = safe ? run_inc : run_ff;
      valley   = closing && (run_end != '0) && (CW'(run_end) >= CW'(min_beams));
      pos_in   = index_ff - (run_end >> 1);
      run_in   = closing ? '0 : run_inc;
      index_in = in_last_ff ? '0 : idx_inc;
      ctl_in.vld    = in_vld_ff;
      ctl_in.valley = in_vld_ff && valley;
      ctl_in.last   = in_vld_ff && in_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         index_ff  <= '0;
         run_ff    <= '0;
         ctl_ff    <= '0;
      end else if (adv) begin
         in_vld_ff <= in_vld;
         ctl_ff    <= ctl_in;
         if (in_vld_ff) begin
            index_ff <= index_in;
            run_ff   <= run_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_range_ff   <= in_range;
         in_invalid_ff <= in_invalid;
         in_last_ff    <= in_last;
         pos_ff        <= pos_in;
      end
   end

   assign ctl_o = ctl_ff;
   assign pos_o = pos_ff;

   a_scan_restart: assert property (@(posedge clock) disable iff (reset)
      (adv && in_vld_ff && in_last_ff) |=> (index_ff == '0 && run_ff == '0))
      else $error("scan state not cleared after last beam");

   a_invalid_extends_run: assert property (@(posedge clock) disable iff (reset)
      (adv && in_vld_ff && !in_last_ff && in_invalid_ff) |=> (run_ff != '0))
      else $error("invalid beam did not extend the run");

endmodule

`default_nettype wire

/* hdl/sgs_heading.sv */
// Valley heading product with saturation, then distance from 90 degrees and turn band.
// Depends on sgs_pkg.
`default_nettype none

module sgs_heading #(
   parameter int IDX_W     = 12,
   parameter int FRAC_BITS = sgs_pkg::DEF_FRAC_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  sgs_pkg::stage_ctl_type     ctl_i,
   input  logic [IDX_W-1:0]           pos_i,
   input  logic [sgs_pkg::STEP_W-1:0] step_i,
   output sgs_pkg::stage_ctl_type     ctl_o,
   output logic [sgs_pkg::ROT_W-1:0]  delta_o,
   output sgs_pkg::band_type          band_o,
   output logic                       left_o
);
   import sgs_pkg::*;

   localparam int PW = IDX_W + STEP_W;
   localparam int XW = (PW > ROT_W) ? PW : ROT_W + 1;
   localparam int NW = ((FRAC_BITS + 7 > ROT_W) ? FRAC_BITS + 7 : ROT_W) + 1;
   localparam logic [NW-1:0] NINETY = NW'(90) << FRAC_BITS;
   localparam logic [NW-1:0] DEG60  = NW'(60) << FRAC_BITS;
   localparam logic [NW-1:0] DEG30  = NW'(30) << FRAC_BITS;
   localparam logic [NW-1:0] DEG10  = NW'(10) << FRAC_BITS;
   localparam logic [NW-1:0] DEG5   = NW'(5) << FRAC_BITS;
   localparam logic [NW-1:0] DEG2   = NW'(2) << FRAC_BITS;

   // multiply stage
   stage_ctl_type    a_ctl_ff;
   logic [ROT_W-1:0] head_ff, head_in;
   logic [XW-1:0]    prod;

   always_comb begin
      prod    = XW'(pos_i) * XW'(step_i);
      head_in = (|prod[XW-1:ROT_W]) ? '1 : prod[ROT_W-1:0];
   end

   // distance and band stage
   stage_ctl_type    b_ctl_ff;
   logic [ROT_W-1:0] delta_ff, delta_in;
   band_type         band_ff, band_in;
   logic             left_ff, left_in;
   logic [NW-1:0]    head_w, diff, delta_w;

   always_comb begin
      head_w   = NW'(head_ff);
      left_in  = head_w >= NINETY;
      diff     = left_in ? head_w - NINETY : NINETY - head_w;
      delta_in = (|diff[NW-1:ROT_W]) ? '1 : diff[ROT_W-1:0];
      delta_w  = NW'(delta_in);
      priority if (delta_w >= DEG60) band_in = BAND_60;
      else if (delta_w >= DEG30)     band_in = BAND_30;
      else if (delta_w >= DEG10)     band_in = BAND_10;
      else if (delta_w >= DEG5)      band_in = BAND_5;
      else if (delta_w >= DEG2)      band_in = BAND_2;
      else                           band_in = BAND_FWD;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
         b_ctl_ff <= '0;
      end else if (adv) begin
         a_ctl_ff <= ctl_i;
         b_ctl_ff <= a_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         head_ff  <= head_in;
         delta_ff <= delta_in;
         band_ff  <= band_in;
         left_ff  <= left_in;
      end
   end

   assign ctl_o   = b_ctl_ff;
   assign delta_o = delta_ff;
   assign band_o  = band_ff;
   assign left_o  = left_ff;

endmodule

`default_nettype wire

/* hdl/sgs_select.sv */
// Best-valley tracking over a scan and the result register with its stall control.
// Depends on sgs_pkg.
`default_nettype none

module sgs_select (
   input  logic                      clock,
   input  logic                      reset,
   input  sgs_pkg::stage_ctl_type    ctl_i,
   input  logic [sgs_pkg::ROT_W-1:0] delta_i,
   input  sgs_pkg::band_type         band_i,
   input  logic                      left_i,
   output logic                      adv,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output sgs_pkg::cmd_type          rsp_cmd,
   output logic [sgs_pkg::ROT_W-1:0] rsp_rot,
   output logic                      rsp_found
);
   import sgs_pkg::*;

   logic             any_ff, any_in;
   logic [ROT_W-1:0] best_delta_ff, best_delta_in;
   band_type         best_band_ff, best_band_in;
   logic             best_left_ff, best_left_in;
   logic             rsp_vld_ff;
   cmd_type          rsp_cmd_ff;
   logic [ROT_W-1:0] rsp_rot_ff;
   logic             rsp_found_ff;
   logic             take;

   always_comb begin
      adv           = !ctl_i.last || !rsp_vld_ff || rsp_ready;
      take          = ctl_i.valley && (!any_ff || (delta_i < best_delta_ff));
      any_in        = any_ff || ctl_i.valley;
      best_delta_in = take ? delta_i : best_delta_ff;
      best_band_in  = take ? band_i : best_band_ff;
      best_left_in  = take ? left_i : best_left_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         any_ff        <= 1'b0;
         best_delta_ff <= '1;
         rsp_vld_ff    <= 1'b0;
      end else begin
         if (adv && ctl_i.vld) begin
            if (ctl_i.last) begin
               any_ff        <= 1'b0;
               best_delta_ff <= '1;
            end else begin
               any_ff        <= any_in;
               best_delta_ff <= best_delta_in;
            end
         end
         if (adv && ctl_i.last) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && ctl_i.vld) begin
         best_band_ff <= best_band_in;
         best_left_ff <= best_left_in;
      end
      if (adv && ctl_i.last) begin
         rsp_cmd_ff   <= any_in ? cmd_for(best_left_in, best_band_in) : CMD_BACK;
         rsp_rot_ff   <= any_in ? best_delta_in : '0;
         rsp_found_ff <= any_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_cmd   = rsp_cmd_ff;
   assign rsp_rot   = rsp_rot_ff;
   assign rsp_found = rsp_found_ff;

   a_no_valley_backs: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_found_ff) |-> (rsp_cmd_ff == CMD_BACK && rsp_rot_ff == '0))
      else $error("back command expected with zero rotation");

   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(ctl_i.last))
      else $error("result raised without a last beam");

endmodule

`default_nettype wire
